// ----- rtl/jbe_pkg.sv -----
// ----------------------------------------------------------------------------
// jbe_pkg: shared types and constants for the integer bytecode execute core
// Opcode classes, fault codes and the decoded item passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package jbe_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int LOCAL_COUNT_DEF = 16;
    localparam logic [4:0] LOCALS_RESET = 5'd16;
    localparam logic [4:0] SHIFT_MASK = 5'b11111;

    localparam logic [2:0] FLT_OK    = 3'd0;
    localparam logic [2:0] FLT_UNSUP = 3'd1;
    localparam logic [2:0] FLT_UNDER = 3'd2;
    localparam logic [2:0] FLT_OVER  = 3'd3;
    localparam logic [2:0] FLT_LOCAL = 3'd4;

    localparam logic [3:0] K_PUSHC  = 4'd0;  // push constant value
    localparam logic [3:0] K_LOAD   = 4'd1;
    localparam logic [3:0] K_STORE  = 4'd2;
    localparam logic [3:0] K_IINC   = 4'd3;
    localparam logic [3:0] K_ADD    = 4'd4;
    localparam logic [3:0] K_SUB    = 4'd5;
    localparam logic [3:0] K_MUL    = 4'd6;
    localparam logic [3:0] K_SHL    = 4'd7;
    localparam logic [3:0] K_SHR    = 4'd8;
    localparam logic [3:0] K_IF1    = 4'd9;
    localparam logic [3:0] K_IF2    = 4'd10;
    localparam logic [3:0] K_GOTO   = 4'd11;
    localparam logic [3:0] K_RET    = 4'd12;
    localparam logic [3:0] K_IRET   = 4'd13;
    localparam logic [3:0] K_POP    = 4'd14;
    localparam logic [3:0] K_UNSUP  = 4'd15;

    localparam logic [7:0] OP_BIPUSH = 8'h10;
    localparam logic [7:0] OP_SIPUSH = 8'h11;
    localparam logic [7:0] OP_ILOAD  = 8'h15;
    localparam logic [7:0] OP_ISTORE = 8'h36;
    localparam logic [7:0] OP_POP    = 8'h57;
    localparam logic [7:0] OP_IADD   = 8'h60;
    localparam logic [7:0] OP_ISUB   = 8'h64;
    localparam logic [7:0] OP_IMUL   = 8'h68;
    localparam logic [7:0] OP_ISHL   = 8'h78;
    localparam logic [7:0] OP_ISHR   = 8'h7A;
    localparam logic [7:0] OP_IINC   = 8'h84;
    localparam logic [7:0] OP_GOTO   = 8'hA7;
    localparam logic [7:0] OP_IRET   = 8'hAC;
    localparam logic [7:0] OP_RET    = 8'hB1;
    localparam logic [7:0] OP_GETST  = 8'hB2;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  lidx;     // local index when used
        logic        uses_local;
        logic [2:0]  cond;     // eq ne lt ge gt le
        logic [31:0] imm;      // pushed constant or iinc increment
        logic [15:0] off;      // branch offset
        logic [15:0] len;      // instruction length
    } dec_t;

    typedef struct packed {
        logic [15:0] pc_step;
        logic        done_res;
        logic        has_value;
        logic [31:0] return_value;
        logic [2:0]  fault;
        logic [4:0]  stack_level;
    } res_t;

endpackage
`default_nettype wire

// ----- rtl/java_int_bytecode_execute_core.sv -----
// ----------------------------------------------------------------------------
// java_int_bytecode_execute_core: integer bytecode execute unit, top level
// Front decode, two-entry queue, back end with stack and locals.
// ----------------------------------------------------------------------------
// One bytecode item (opcode plus two code bytes) enters per cycle and one
// result item leaves per cycle in steady state. An item is decoded in the
// front end, waits in a two-entry queue, and is executed by the back end
// against the operand stack and local slots (reset clears the locals, the
// stack count goes to zero). The decoded item is registered in the queue,
// and its result is registered in the back end's result register; the back
// end's stack update, made as each item is taken, is what sets the
// one-item-per-cycle rate. A held result stalls the back end, and the input
// stalls once the queue holds two items. The cfg channel sets locals_in_use
// (reset 16) and is to be written only while no item is in flight.
`default_nettype none
module java_int_bytecode_execute_core #(
    parameter int STACK_DEPTH = jbe_pkg::STACK_DEPTH_DEF,
    parameter int LOCAL_COUNT = jbe_pkg::LOCAL_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data,      // locals_in_use
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // req_type, operand_hi, operand_lo
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata        // pc_step, done_res, has_value,
                                            // return_value, fault, stack_level
);
    logic [4:0]    locals_reg;
    logic          q_valid, q_ready;
    jbe_pkg::dec_t q_data;
    jbe_pkg::res_t r;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) locals_reg <= jbe_pkg::LOCALS_RESET;
        else if (cfg_valid) locals_reg <= cfg_data;
    end

    jbe_decode u_dec (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .op(s_tdata[7:0]), .hi(s_tdata[15:8]), .lo(s_tdata[23:16]),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    jbe_execute #(.STACK_DEPTH(STACK_DEPTH), .LOCAL_COUNT(LOCAL_COUNT)) u_exe (
        .aclk(aclk), .aresetn(aresetn), .locals_in_use(locals_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .r_valid(m_tvalid), .r_ready(m_tready), .r_data(r)
    );

    assign m_tdata = {6'b0, r.stack_level, r.fault, r.return_value,
                      r.has_value, r.done_res, r.pc_step};
endmodule
`default_nettype wire

// ----- rtl/jbe_decode.sv -----
// ----------------------------------------------------------------------------
// jbe_decode: front end
// Accepts bytecode items, classifies the opcode and queues the decoded item.
// ----------------------------------------------------------------------------
`default_nettype none
module jbe_decode (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    op,
    input  wire logic [7:0]    hi,
    input  wire logic [7:0]    lo,
    output logic               q_valid,
    input  wire logic          q_ready,
    output jbe_pkg::dec_t      q_data
);
    jbe_pkg::dec_t d;
    jbe_pkg::dec_t q_mem [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    always_comb begin
        d = '0;
        d.off = {hi, lo};
        d.lidx = hi;
        d.len = 16'd1;
        d.kind = jbe_pkg::K_UNSUP;
        if (op >= 8'h02 && op <= 8'h08) begin
            d.kind = jbe_pkg::K_PUSHC;
            d.imm = {{24{op[7]}}, op} - 32'd3;
        end else begin
            case (op)
                jbe_pkg::OP_BIPUSH: begin
                    d.kind = jbe_pkg::K_PUSHC; d.imm = {{24{hi[7]}}, hi}; d.len = 16'd2;
                end
                jbe_pkg::OP_SIPUSH: begin
                    d.kind = jbe_pkg::K_PUSHC; d.imm = {{16{hi[7]}}, hi, lo};
                    d.len = 16'd3;
                end
                jbe_pkg::OP_GETST: begin
                    d.kind = jbe_pkg::K_PUSHC; d.len = 16'd3;
                end
                jbe_pkg::OP_ILOAD: begin
                    d.kind = jbe_pkg::K_LOAD; d.uses_local = 1'b1; d.len = 16'd2;
                end
                jbe_pkg::OP_ISTORE: begin
                    d.kind = jbe_pkg::K_STORE; d.uses_local = 1'b1; d.len = 16'd2;
                end
                jbe_pkg::OP_IINC: begin
                    d.kind = jbe_pkg::K_IINC; d.uses_local = 1'b1; d.len = 16'd3;
                    d.imm = {{24{lo[7]}}, lo};
                end
                jbe_pkg::OP_IADD: d.kind = jbe_pkg::K_ADD;
                jbe_pkg::OP_ISUB: d.kind = jbe_pkg::K_SUB;
                jbe_pkg::OP_IMUL: d.kind = jbe_pkg::K_MUL;
                jbe_pkg::OP_ISHL: d.kind = jbe_pkg::K_SHL;
                jbe_pkg::OP_ISHR: d.kind = jbe_pkg::K_SHR;
                jbe_pkg::OP_GOTO: d.kind = jbe_pkg::K_GOTO;
                jbe_pkg::OP_RET:  begin d.kind = jbe_pkg::K_RET; d.len = '0; end
                jbe_pkg::OP_IRET: begin d.kind = jbe_pkg::K_IRET; d.len = '0; end
                jbe_pkg::OP_POP:  d.kind = jbe_pkg::K_POP;
                default: begin
                    if (op >= 8'h1A && op <= 8'h1D) begin
                        d.kind = jbe_pkg::K_LOAD; d.uses_local = 1'b1;
                        d.lidx = op - 8'h1A;
                    end else if (op >= 8'h3B && op <= 8'h3E) begin
                        d.kind = jbe_pkg::K_STORE; d.uses_local = 1'b1;
                        d.lidx = op - 8'h3B;
                    end else if (op >= 8'h99 && op <= 8'h9E) begin
                        d.kind = jbe_pkg::K_IF1; d.cond = 3'(op - 8'h99); d.len = 16'd3;
                    end else if (op >= 8'h9F && op <= 8'hA4) begin
                        d.kind = jbe_pkg::K_IF2; d.cond = 3'(op - 8'h9F); d.len = 16'd3;
                    end
                end
            endcase
        end
    end

    // two-entry queue between front and back
    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = q_mem[rp_reg];
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wp_reg] <= d;
        end
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
        end
    end

`ifndef SYNTH
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !in_ready) else $error("accept while queue full");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count lost an item");
`endif
endmodule
`default_nettype wire

// ----- rtl/jbe_execute.sv -----
// ----------------------------------------------------------------------------
// jbe_execute: back end
// Holds the operand stack and locals, executes one decoded item per cycle unless a held result stalls it.
// ----------------------------------------------------------------------------
`default_nettype none
module jbe_execute #(
    parameter int STACK_DEPTH = jbe_pkg::STACK_DEPTH_DEF,
    parameter int LOCAL_COUNT = jbe_pkg::LOCAL_COUNT_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [4:0]    locals_in_use,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire jbe_pkg::dec_t q_data,
    output logic               r_valid,
    input  wire logic          r_ready,
    output jbe_pkg::res_t      r_data
);
    localparam int SW = $clog2(STACK_DEPTH + 1);
    localparam int SI = $clog2(STACK_DEPTH);
    localparam int LI = $clog2(LOCAL_COUNT);

    logic [31:0] stk_reg [STACK_DEPTH];
    logic [31:0] loc_reg [LOCAL_COUNT];
    logic [SW-1:0] sp_reg, sp_next;
    logic        rv_reg;
    jbe_pkg::res_t res_reg, res_next;

    logic        go, ok;
    logic [1:0]  pops;
    logic        pushes;
    logic [31:0] a, b, r, lval;
    logic [4:0]  sh;
    logic        cmp;
    logic signed [31:0] sa, sb;
    logic [LI-1:0] li;
    logic        lbad;
    logic [SW-1:0] top1, top2;
    logic [2:0]  fault;
    logic [SW:0] after;

    assign q_ready = !rv_reg || r_ready;
    assign go = q_valid && q_ready;
    assign r_valid = rv_reg;
    assign r_data = res_reg;

    assign top1 = sp_reg - SW'(1);
    assign top2 = sp_reg - SW'(2);
    assign li = q_data.lidx[LI-1:0];
    assign lval = loc_reg[li];

    always_comb begin
        pops = 2'd0;
        pushes = 1'b0;
        case (q_data.kind)
            jbe_pkg::K_PUSHC, jbe_pkg::K_LOAD: pushes = 1'b1;
            jbe_pkg::K_STORE, jbe_pkg::K_IF1, jbe_pkg::K_IRET, jbe_pkg::K_POP: pops = 2'd1;
            jbe_pkg::K_ADD, jbe_pkg::K_SUB, jbe_pkg::K_MUL, jbe_pkg::K_SHL,
            jbe_pkg::K_SHR: begin pops = 2'd2; pushes = 1'b1; end
            jbe_pkg::K_IF2: pops = 2'd2;
            default: ;
        endcase
        lbad = q_data.uses_local && ({3'b0, q_data.lidx[7:5] != 3'b0, q_data.lidx[4:0]} >=
               {4'b0, locals_in_use} || 32'(q_data.lidx) >= LOCAL_COUNT);
        after = {1'b0, sp_reg} - (SW+1)'(pops) + (SW+1)'(pushes);
        if (q_data.kind == jbe_pkg::K_UNSUP) fault = jbe_pkg::FLT_UNSUP;
        else if (lbad) fault = jbe_pkg::FLT_LOCAL;
        else if (32'(sp_reg) < 32'(pops)) fault = jbe_pkg::FLT_UNDER;
        else if (32'(after) > STACK_DEPTH) fault = jbe_pkg::FLT_OVER;
        else fault = jbe_pkg::FLT_OK;
        ok = (fault == jbe_pkg::FLT_OK);
    end

    // operand fetch: b is the top, a the one below
    always_comb begin
        b = stk_reg[top1[SI-1:0]];
        a = (pops == 2'd2) ? stk_reg[top2[SI-1:0]] : b;
        sa = a;
        sb = (q_data.kind == jbe_pkg::K_IF1) ? 32'sd0 : b;
        if (q_data.kind == jbe_pkg::K_IF1) sa = b;
        sh = b[4:0] & jbe_pkg::SHIFT_MASK;
        case (q_data.cond)
            3'd0: cmp = (sa == sb);
            3'd1: cmp = (sa != sb);
            3'd2: cmp = (sa < sb);
            3'd3: cmp = (sa >= sb);
            3'd4: cmp = (sa > sb);
            default: cmp = (sa <= sb);
        endcase
        case (q_data.kind)
            jbe_pkg::K_PUSHC: r = q_data.imm;
            jbe_pkg::K_LOAD:  r = lval;
            jbe_pkg::K_ADD:   r = a + b;
            jbe_pkg::K_SUB:   r = a - b;
            jbe_pkg::K_MUL:   r = a * b;
            jbe_pkg::K_SHL:   r = a << sh;
            jbe_pkg::K_SHR:   r = 32'($signed(a) >>> sh);
            default:          r = '0;
        endcase
    end

    always_comb begin
        sp_next = sp_reg;
        res_next = '0;
        if (ok) begin
            sp_next = after[SW-1:0];
            res_next.pc_step = q_data.len;
            case (q_data.kind)
                jbe_pkg::K_IF1, jbe_pkg::K_IF2:
                    if (cmp) res_next.pc_step = q_data.off;
                jbe_pkg::K_GOTO: res_next.pc_step = q_data.off;
                jbe_pkg::K_RET:  res_next.done_res = 1'b1;
                jbe_pkg::K_IRET: begin
                    res_next.done_res = 1'b1;
                    res_next.has_value = 1'b1;
                    res_next.return_value = b;
                end
                default: ;
            endcase
        end
        res_next.fault = fault;
        res_next.stack_level = 5'(ok ? after : {1'b0, sp_reg});
    end

    always_ff @(posedge aclk) begin
        if (go && ok) begin
            if (pushes) stk_reg[(pops == 2'd2) ? top2[SI-1:0] : sp_reg[SI-1:0]] <= r;
        end
        if (go) res_reg <= res_next;
        if (!aresetn) begin
            sp_reg <= '0;
            rv_reg <= 1'b0;
            for (int i = 0; i < LOCAL_COUNT; i++) loc_reg[i] <= '0;
        end else begin
            if (go) sp_reg <= sp_next;
            if (go) rv_reg <= 1'b1;
            else if (r_ready) rv_reg <= 1'b0;
            if (go && ok) begin
                if (q_data.kind == jbe_pkg::K_STORE) loc_reg[li] <= b;
                else if (q_data.kind == jbe_pkg::K_IINC) loc_reg[li] <= lval + q_data.imm;
            end
        end
    end

`ifndef SYNTH
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(sp_reg) <= STACK_DEPTH) else $error("stack pointer past depth");
    a_fault_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && !ok) |=> (sp_reg == $past(sp_reg))) else $error("fault changed stack");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (rv_reg && !r_ready) |=> $stable(res_reg)) else $error("result lost");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench for java_int_bytecode_execute_core
// Drives bytecode items with random bursts and gaps, predicts every result
// from a private model of the stack and locals, and checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NDEPTH = 16;
    localparam int NLOCAL = 16;
    localparam int LATENCY = 8;

    // opcodes not named in the package
    localparam logic [7:0] OP_ICONST_M1 = 8'h02;
    localparam logic [7:0] OP_ICONST_5  = 8'h08;
    localparam logic [7:0] OP_ILOAD_0   = 8'h1A;
    localparam logic [7:0] OP_ILOAD_3   = 8'h1D;
    localparam logic [7:0] OP_ISTORE_0  = 8'h3B;
    localparam logic [7:0] OP_ISTORE_3  = 8'h3E;
    localparam logic [7:0] OP_IFEQ      = 8'h99;
    localparam logic [7:0] OP_IFLE      = 8'h9E;
    localparam logic [7:0] OP_IFCMPEQ   = 8'h9F;
    localparam logic [7:0] OP_IFCMPLE   = 8'hA4;
    localparam logic [7:0] OP_INVSTAT   = 8'hB8;
    localparam logic [7:0] OP_INVVIRT   = 8'hB6;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    java_int_bytecode_execute_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata),   // req_type, operand_hi, operand_lo
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)    // pc_step, done_res, has_value, return_value,
                             // fault, stack_level
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predictor state
    logic [31:0] mdl_stack [NDEPTH];
    logic [31:0] mdl_locals [NLOCAL];
    int unsigned mdl_depth;
    logic [4:0]  mdl_lim;

    jbe_pkg::res_t exp_results [$];
    int   err_count = 0;
    int   n_sent = 0;
    int   n_checked = 0;

    // receiver control
    int   hold_cycles = 0;   // long hold-off counter
    int   stall_pct = 30;
    int   burst_max = 8;
    int   gap_max = 4;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= 40)
            $display("MISMATCH item %0d %s: got %h want %h", n_checked, what, got, want);
    endtask

    function automatic logic cond_true(input logic [2:0] sel, input logic [31:0] a,
                                       input logic [31:0] b);
        logic signed [31:0] x, y;
        x = a;
        y = b;
        case (sel)
            3'd0: return x == y;
            3'd1: return x != y;
            3'd2: return x < y;
            3'd3: return x >= y;
            3'd4: return x > y;
            default: return x <= y;
        endcase
    endfunction

    // predict one bytecode and update the model state
    function automatic jbe_pkg::res_t exec_bytecode(input logic [7:0] op,
                                                    input logic [7:0] hi,
                                                    input logic [7:0] lo);
        jbe_pkg::res_t r;
        int pops, pushes, lidx;
        logic [2:0] flt;
        logic [15:0] off;
        logic [31:0] a, b, v;
        pops = 0; pushes = 0; lidx = -1; flt = jbe_pkg::FLT_OK;
        off = {hi, lo};
        r = '0;
        if (op >= OP_ICONST_M1 && op <= OP_ICONST_5) pushes = 1;
        else if (op == jbe_pkg::OP_BIPUSH || op == jbe_pkg::OP_SIPUSH ||
                 op == jbe_pkg::OP_GETST) pushes = 1;
        else if (op == jbe_pkg::OP_ILOAD) begin pushes = 1; lidx = hi; end
        else if (op >= OP_ILOAD_0 && op <= OP_ILOAD_3) begin
            pushes = 1; lidx = op - OP_ILOAD_0;
        end
        else if (op == jbe_pkg::OP_ISTORE) begin pops = 1; lidx = hi; end
        else if (op >= OP_ISTORE_0 && op <= OP_ISTORE_3) begin
            pops = 1; lidx = op - OP_ISTORE_0;
        end
        else if (op == jbe_pkg::OP_IINC) lidx = hi;
        else if (op == jbe_pkg::OP_IADD || op == jbe_pkg::OP_ISUB ||
                 op == jbe_pkg::OP_IMUL || op == jbe_pkg::OP_ISHL ||
                 op == jbe_pkg::OP_ISHR) begin
            pops = 2; pushes = 1;
        end
        else if (op >= OP_IFEQ && op <= OP_IFLE) pops = 1;
        else if (op >= OP_IFCMPEQ && op <= OP_IFCMPLE) pops = 2;
        else if (op == jbe_pkg::OP_GOTO || op == jbe_pkg::OP_RET) pops = 0;
        else if (op == jbe_pkg::OP_IRET || op == jbe_pkg::OP_POP) pops = 1;
        else flt = jbe_pkg::FLT_UNSUP;

        if (flt == jbe_pkg::FLT_OK && lidx >= 0 && (lidx >= mdl_lim || lidx >= NLOCAL))
            flt = jbe_pkg::FLT_LOCAL;
        if (flt == jbe_pkg::FLT_OK && mdl_depth < pops) flt = jbe_pkg::FLT_UNDER;
        if (flt == jbe_pkg::FLT_OK && mdl_depth - pops + pushes > NDEPTH)
            flt = jbe_pkg::FLT_OVER;

        if (flt == jbe_pkg::FLT_OK) begin
            if (op >= OP_ICONST_M1 && op <= OP_ICONST_5) begin
                v = 32'(op) - 32'd3; mdl_stack[mdl_depth++] = v; r.pc_step = 1;
            end else if (op == jbe_pkg::OP_BIPUSH) begin
                mdl_stack[mdl_depth++] = {{24{hi[7]}}, hi}; r.pc_step = 2;
            end else if (op == jbe_pkg::OP_SIPUSH) begin
                mdl_stack[mdl_depth++] = {{16{off[15]}}, off}; r.pc_step = 3;
            end else if (op == jbe_pkg::OP_GETST) begin
                mdl_stack[mdl_depth++] = '0; r.pc_step = 3;
            end else if (op == jbe_pkg::OP_ILOAD) begin
                mdl_stack[mdl_depth++] = mdl_locals[lidx]; r.pc_step = 2;
            end else if (op >= OP_ILOAD_0 && op <= OP_ILOAD_3) begin
                mdl_stack[mdl_depth++] = mdl_locals[lidx]; r.pc_step = 1;
            end else if (op == jbe_pkg::OP_ISTORE) begin
                mdl_locals[lidx] = mdl_stack[--mdl_depth]; r.pc_step = 2;
            end else if (op >= OP_ISTORE_0 && op <= OP_ISTORE_3) begin
                mdl_locals[lidx] = mdl_stack[--mdl_depth]; r.pc_step = 1;
            end else if (op == jbe_pkg::OP_IINC) begin
                mdl_locals[lidx] = mdl_locals[lidx] + {{24{lo[7]}}, lo}; r.pc_step = 3;
            end else if (pops == 2 && pushes == 1) begin
                b = mdl_stack[--mdl_depth];
                a = mdl_stack[--mdl_depth];
                case (op)
                    jbe_pkg::OP_IADD: v = a + b;
                    jbe_pkg::OP_ISUB: v = a - b;
                    jbe_pkg::OP_IMUL: v = a * b;
                    jbe_pkg::OP_ISHL: v = a << (b & jbe_pkg::SHIFT_MASK);
                    default: v = $signed(a) >>> (b & jbe_pkg::SHIFT_MASK);
                endcase
                mdl_stack[mdl_depth++] = v; r.pc_step = 1;
            end else if (op >= OP_IFEQ && op <= OP_IFLE) begin
                a = mdl_stack[--mdl_depth];
                r.pc_step = cond_true(3'(op - OP_IFEQ), a, '0) ? off : 16'd3;
            end else if (op >= OP_IFCMPEQ && op <= OP_IFCMPLE) begin
                b = mdl_stack[--mdl_depth];
                a = mdl_stack[--mdl_depth];
                r.pc_step = cond_true(3'(op - OP_IFCMPEQ), a, b) ? off : 16'd3;
            end else if (op == jbe_pkg::OP_GOTO) r.pc_step = off;
            else if (op == jbe_pkg::OP_RET) r.done_res = 1'b1;
            else if (op == jbe_pkg::OP_IRET) begin
                r.return_value = mdl_stack[--mdl_depth];
                r.done_res = 1'b1; r.has_value = 1'b1;
            end else begin
                mdl_depth--; r.pc_step = 1;
            end
        end
        r.fault = flt;
        r.stack_level = 5'(mdl_depth);
        return r;
    endfunction

    // send one item with burst/gap idling on the sender side
    int burst_left = 0;
    task automatic send_bytecode(input logic [7:0] op, input logic [7:0] hi,
                                 input logic [7:0] lo);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi, op};
        exp_results.push_back(exec_bytecode(op, hi, lo));
        n_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic stop_sending;
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic drain;
        stop_sending();
        while (exp_results.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_locals_limit(input logic [4:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mdl_lim = v;
        @(posedge aclk);
    endtask

    // receiver: random stall pattern plus an optional long hold-off
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // result checker
    initial begin
        jbe_pkg::res_t got, want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.pc_step      = m_tdata[15:0];
                got.done_res     = m_tdata[16];
                got.has_value    = m_tdata[17];
                got.return_value = m_tdata[49:18];
                got.fault        = m_tdata[52:50];
                got.stack_level  = m_tdata[57:53];
                if (exp_results.size() == 0) begin
                    err_count++;
                    $display("ERROR: result with nothing expected");
                end else begin
                    want = exp_results.pop_front();
                    if (got.pc_step != want.pc_step)
                        report_mismatch("pc_step", got.pc_step, want.pc_step);
                    if (got.done_res != want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                    if (got.has_value != want.has_value)
                        report_mismatch("has_value", got.has_value, want.has_value);
                    if (got.return_value != want.return_value)
                        report_mismatch("return_value", got.return_value,
                                        want.return_value);
                    if (got.fault != want.fault)
                        report_mismatch("fault", got.fault, want.fault);
                    if (got.stack_level != want.stack_level)
                        report_mismatch("stack_level", got.stack_level, want.stack_level);
                    if (m_tdata[63:58] != '0)
                        report_mismatch("pad", m_tdata[63:58], '0);
                    n_checked++;
                end
            end
        end
    end

    // random opcode from a weighted mix; stack-aware so most code runs deep
    function automatic logic [7:0] pick_opcode;
        int k;
        k = $urandom_range(0, 99);
        if (k < 4) return 8'($urandom);                     // noise, mostly unsupported
        if (k < 20) return (mdl_depth < 12) ?
            8'($urandom_range(OP_ICONST_M1, OP_ICONST_5)) : jbe_pkg::OP_POP;
        if (k < 26) return (mdl_depth < 14) ? jbe_pkg::OP_BIPUSH : jbe_pkg::OP_ISTORE;
        if (k < 32) return jbe_pkg::OP_SIPUSH;
        if (k < 37) return jbe_pkg::OP_ILOAD;
        if (k < 41) return 8'($urandom_range(OP_ILOAD_0, OP_ILOAD_3));
        if (k < 46) return jbe_pkg::OP_ISTORE;
        if (k < 49) return 8'($urandom_range(OP_ISTORE_0, OP_ISTORE_3));
        if (k < 53) return jbe_pkg::OP_IINC;
        if (k < 57) return jbe_pkg::OP_IADD;
        if (k < 60) return jbe_pkg::OP_ISUB;
        if (k < 64) return jbe_pkg::OP_IMUL;
        if (k < 67) return jbe_pkg::OP_ISHL;
        if (k < 71) return jbe_pkg::OP_ISHR;
        if (k < 76) return 8'($urandom_range(OP_IFEQ, OP_IFLE));
        if (k < 81) return 8'($urandom_range(OP_IFCMPEQ, OP_IFCMPLE));
        if (k < 84) return jbe_pkg::OP_GOTO;
        if (k < 86) return jbe_pkg::OP_RET;
        if (k < 89) return jbe_pkg::OP_IRET;
        if (k < 92) return jbe_pkg::OP_GETST;
        if (k < 96) return jbe_pkg::OP_POP;
        return (k < 98) ? OP_INVSTAT : OP_INVVIRT;
    endfunction

    task automatic send_random(input int count);
        logic [7:0] op, hi;
        for (int i = 0; i < count; i++) begin
            op = pick_opcode();
            // local indices mostly in range, sometimes out of bounds
            hi = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, NLOCAL - 1))
                                            : 8'($urandom);
            if (!(op == jbe_pkg::OP_ILOAD || op == jbe_pkg::OP_ISTORE ||
                  op == jbe_pkg::OP_IINC)) hi = 8'($urandom);
            send_bytecode(op, hi, 8'($urandom));
        end
    endtask

    task automatic test_directed;
        // push extremes
        send_bytecode(OP_ICONST_M1, 8'h00, 8'h00);
        send_bytecode(OP_ICONST_5, 8'hFF, 8'hFF);
        send_bytecode(jbe_pkg::OP_BIPUSH, 8'h80, 8'h00);
        send_bytecode(jbe_pkg::OP_BIPUSH, 8'h7F, 8'hFF);
        send_bytecode(jbe_pkg::OP_SIPUSH, 8'h80, 8'h00);
        send_bytecode(jbe_pkg::OP_SIPUSH, 8'h7F, 8'hFF);
        send_bytecode(jbe_pkg::OP_GETST, 8'h12, 8'h34);
        // arithmetic right shift by zero, then a left shift whose count uses the low five bits
        send_bytecode(jbe_pkg::OP_ISHR, 8'h00, 8'h00);
        send_bytecode(jbe_pkg::OP_SIPUSH, 8'h00, 8'h21);
        send_bytecode(jbe_pkg::OP_ISHL, 8'h00, 8'h00);
        send_bytecode(jbe_pkg::OP_IMUL, 8'h00, 8'h00);
        send_bytecode(jbe_pkg::OP_ISUB, 8'h00, 8'h00);
        send_bytecode(jbe_pkg::OP_IADD, 8'h00, 8'h00);
        // locals: store, iinc negative, load, bad index
        send_bytecode(jbe_pkg::OP_ISTORE, 8'h0F, 8'h00);
        send_bytecode(jbe_pkg::OP_IINC, 8'h0F, 8'h80);
        send_bytecode(jbe_pkg::OP_ILOAD, 8'h0F, 8'h00);
        send_bytecode(jbe_pkg::OP_ILOAD, 8'h10, 8'h00);
        send_bytecode(jbe_pkg::OP_IINC, 8'hFF, 8'h7F);
        // branches: taken with negative offset, then goto, then ifcmp
        send_bytecode(OP_IFEQ + 8'd1, 8'hFF, 8'hF0);
        send_bytecode(jbe_pkg::OP_GOTO, 8'h80, 8'h00);
        send_bytecode(OP_IFCMPEQ + 8'd2, 8'h00, 8'h08);
        // unsupported and invoke opcodes, underflow, return forms
        send_bytecode(OP_INVSTAT, 8'h00, 8'h01);
        send_bytecode(OP_INVVIRT, 8'h00, 8'h01);
        send_bytecode(jbe_pkg::OP_IRET, 8'h00, 8'h00);
        send_bytecode(jbe_pkg::OP_RET, 8'h00, 8'h00);
        send_bytecode(jbe_pkg::OP_POP, 8'h00, 8'h00);
        drain();
    endtask

    task automatic test_overflow_and_backpressure;
        // hold the receiver off while the stack is filled past its depth
        hold_cycles = 60;
        for (int i = 0; i < NDEPTH + 3; i++)
            send_bytecode(jbe_pkg::OP_BIPUSH, 8'($urandom), 8'h00);
        for (int i = 0; i < NDEPTH + 2; i++) send_bytecode(jbe_pkg::OP_POP, 8'h00, 8'h00);
        drain();
    endtask

    task automatic test_random_sweep;
        logic [4:0] limits [5] = '{5'd16, 5'd0, 5'd31, 5'd4, 5'd1};
        foreach (limits[i]) begin
            write_locals_limit(limits[i]);
            stall_pct = (i == 2) ? 0 : $urandom_range(10, 60);
            gap_max = (i == 3) ? 0 : 5;
            send_random(200);
        end
        write_locals_limit(jbe_pkg::LOCALS_RESET);
        send_random(50);
        drain();
    endtask

    initial begin
        timeout_guard: begin end
        for (int i = 0; i < NLOCAL; i++) mdl_locals[i] = '0;
        for (int i = 0; i < NDEPTH; i++) mdl_stack[i] = '0;
        mdl_depth = 0;
        mdl_lim = jbe_pkg::LOCALS_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow_and_backpressure();
        test_random_sweep();
        $display("Ran %0d bytecode items, %0d results checked, over five locals limits",
                 n_sent, n_checked);
        $display("including stack overflow under receiver hold-off and fault paths");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout waiting for results");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
